/* src/wlb_pkg.sv */
// shared types and constants for the weighted linear binning block
package wlb_pkg;

  localparam int SUM_W = 48;
  localparam int DVD_W = 64;
  localparam int CNT_W = 7;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_ADD   = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_WEIGHT_BAD = 3'd1,
    ST_OUTSIDE    = 3'd2,
    ST_GRID_BAD   = 3'd3,
    ST_NO_MASS    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    DIV_CELL  = 2'd0,
    DIV_SHARE = 2'd1,
    DIV_NORM  = 2'd2
  } div_mode_t;

  typedef enum logic [1:0] {
    ADDR_LEFT  = 2'd0,
    ADDR_RIGHT = 2'd1,
    ADDR_INDEX = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    VAL_ZERO = 2'd0,
    VAL_QUO  = 2'd1,
    VAL_ONES = 2'd2
  } val_sel_t;

  typedef enum logic [3:0] {
    S_INIT_CLR,
    S_IDLE,
    S_CLR,
    S_ADD_CHK,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_CELL,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_RD_L,
    S_WR_L,
    S_RD_R,
    S_WR_R,
    S_RD_CHK,
    S_RD_DIV,
    S_RD_WAIT
  } state_t;

  typedef struct packed {
    logic      load;
    logic      sweep;
    logic      clr_total;
    logic      mul1;
    logic      mul2;
    logic      div_go;
    div_mode_t div_mode;
    logic      rd;
    addr_sel_t rd_sel;
    logic      wr_left;
    logic      wr_right;
    logic      add_total;
    logic      finish;
    status_t   fin_code;
    val_sel_t  fin_val;
  } cmd_t;

  typedef struct packed {
    action_t action;
    logic    grid_ok;
    logic    w_pos;
    logic    d_neg;
    logic    idx_bad;
    logic    total_zero;
    logic    cell_bad;
    logic    div_done;
    logic    sweep_last;
    logic    rd_sat;
  } stat_t;

endpackage

/* src/wlb_div.sv */
// restoring divider, one quotient bit per cycle
module wlb_div import wlb_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               go,
  input  logic [SUM_W-1:0]   rem_init,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [CNT_W-1:0]   steps,
  input  logic [SUM_W-1:0]   divisor,
  output logic               done,
  output logic [DVD_W-1:0]   quo,
  output logic [SUM_W-1:0]   rem
);

  logic [DVD_W-1:0] dvd;
  logic [SUM_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [SUM_W:0]   trial;
  logic [SUM_W:0]   diff;

  assign trial = {rem, dvd[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= steps;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= rem_init;
      dvd <= dividend;
      dsr <= divisor;
      quo <= '0;
    end else if (run) begin
      dvd <= {dvd[DVD_W-2:0], 1'b0};
      if (!diff[SUM_W]) begin
        rem <= diff[SUM_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b1};
      end else begin
        rem <= trial[SUM_W-1:0];
        quo <= {quo[DVD_W-2:0], 1'b0};
      end
    end
  end

endmodule

/* src/wlb_dp.sv */
// datapath: config, item registers, bin memory, multipliers, divider, result
module wlb_dp import wlb_pkg::*; #(
  parameter int BINS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic [1:0]  action,
  input  logic [31:0] sample,
  input  logic [31:0] weight,
  input  logic [9:0]  bin_index,
  input  cmd_t        cmd,
  output stat_t       stat,
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] bin_value
);

  localparam int IW = $clog2(BINS);
  localparam logic [SUM_W-1:0] BM1 = SUM_W'(BINS - 1);
  localparam logic [DVD_W-1:0] BM1_Q = DVD_W'(BINS - 1);
  localparam logic [16:0] BINS_L = 17'(BINS);
  localparam logic [IW-1:0] LAST = IW'(BINS - 1);

  logic [31:0] mesh_low;
  logic [31:0] mesh_high;
  logic [1:0]  act_q;
  logic [31:0] sample_q;
  logic [31:0] weight_q;
  logic [9:0]  idx_q;

  logic [SUM_W-1:0] total;
  logic [SUM_W-1:0] num;
  logic [62:0]      prod;
  logic [IW-1:0]    left_bin;
  logic [IW-1:0]    sweep_cnt;

  logic [SUM_W-1:0] mem [BINS];
  logic [SUM_W-1:0] rdata;
  logic [IW-1:0]    raddr;

  logic signed [32:0] d;
  logic signed [32:0] den;

  logic             div_go;
  logic [SUM_W-1:0] div_rem_init;
  logic [DVD_W-1:0] div_dvd;
  logic [CNT_W-1:0] div_steps;
  logic [SUM_W-1:0] div_dsr;
  logic             div_done;
  logic [DVD_W-1:0] quo;
  logic [SUM_W-1:0] rem;

  logic [31:0]      w_right;
  logic [31:0]      w_left;
  logic [SUM_W:0]   sum_l;
  logic [SUM_W:0]   sum_r;
  logic [SUM_W:0]   sum_t;

  assign d   = $signed({sample_q[31], sample_q}) - $signed({mesh_low[31], mesh_low});
  assign den = $signed({mesh_high[31], mesh_high}) - $signed({mesh_low[31], mesh_low});

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_low  <= 32'd0;
      mesh_high <= 32'd67043328;
    end else if (cfg_we) begin
      if (cfg_index) mesh_high <= cfg_data;
      else mesh_low <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q    <= action;
      sample_q <= sample;
      weight_q <= weight;
      idx_q    <= bin_index;
    end
    if (cmd.mul1) num <= {16'd0, d[31:0]} * BM1;
    if (cmd.mul2) begin
      prod     <= 63'(weight_q[30:0]) * 63'(rem[31:0]);
      left_bin <= quo[IW-1:0];
    end
  end

  // divider operand selection
  always_comb begin
    div_go       = cmd.div_go;
    div_rem_init = '0;
    div_dvd      = '0;
    div_steps    = CNT_W'(SUM_W);
    div_dsr      = {16'd0, den[31:0]};
    unique case (cmd.div_mode)
      DIV_CELL: begin
        div_dvd   = {num, 16'd0};
        div_steps = CNT_W'(SUM_W);
      end
      DIV_SHARE: begin
        div_dvd   = {1'b0, prod};
        div_steps = CNT_W'(DVD_W);
      end
      DIV_NORM: begin
        div_rem_init = rdata;
        div_steps    = CNT_W'(32);
        div_dsr      = total;
      end
      default: begin
        div_dvd = '0;
      end
    endcase
  end

  wlb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .rem_init (div_rem_init),
    .dividend (div_dvd),
    .steps    (div_steps),
    .divisor  (div_dsr),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  assign w_right = quo[31:0];
  assign w_left  = weight_q - w_right;
  assign sum_l   = {1'b0, rdata} + (SUM_W + 1)'(w_left);
  assign sum_r   = {1'b0, rdata} + (SUM_W + 1)'(w_right);
  assign sum_t   = {1'b0, total} + (SUM_W + 1)'(weight_q);

  always_comb begin
    unique case (cmd.rd_sel)
      ADDR_LEFT:  raddr = left_bin;
      ADDR_RIGHT: raddr = left_bin + 1'b1;
      ADDR_INDEX: raddr = IW'(idx_q);
      default:    raddr = left_bin;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) mem[sweep_cnt] <= '0;
    else if (cmd.wr_left) mem[left_bin] <= sum_l[SUM_W] ? '1 : sum_l[SUM_W-1:0];
    else if (cmd.wr_right) mem[left_bin + 1'b1] <= sum_r[SUM_W] ? '1 : sum_r[SUM_W-1:0];
    if (cmd.rd) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_cnt <= '0;
      total     <= '0;
      done      <= 1'b0;
    end else begin
      if (cmd.sweep) sweep_cnt <= (sweep_cnt == LAST) ? '0 : sweep_cnt + 1'b1;
      if (cmd.clr_total) total <= '0;
      else if (cmd.add_total) total <= sum_t[SUM_W] ? '1 : sum_t[SUM_W-1:0];
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status <= cmd.fin_code;
      unique case (cmd.fin_val)
        VAL_QUO:  bin_value <= quo[31:0];
        VAL_ONES: bin_value <= '1;
        default:  bin_value <= '0;
      endcase
    end
  end

  assign stat.action     = action_t'(act_q);
  assign stat.grid_ok    = $signed(mesh_high) > $signed(mesh_low);
  assign stat.w_pos      = !weight_q[31] && (weight_q != 32'd0);
  assign stat.d_neg      = d[32];
  assign stat.idx_bad    = 17'(idx_q) >= BINS_L;
  assign stat.total_zero = total == '0;
  assign stat.cell_bad   = quo >= BM1_Q;
  assign stat.div_done   = div_done;
  assign stat.sweep_last = sweep_cnt == LAST;
  assign stat.rd_sat     = rdata >= total;

endmodule

/* src/wlb_ctrl.sv */
// controller state machine for the binning block
module wlb_ctrl import wlb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT_CLR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_INIT_CLR: if (stat.sweep_last) state_next = S_IDLE;
      S_IDLE: begin
        if (start) begin
          state_next = S_ADD_CHK;
        end
      end
      default: state_next = state;
    endcase
    // item dispatch and the rest of the sequence
    unique case (state)
      S_IDLE: begin
        if (start) state_next = S_ADD_CHK;
      end
      S_ADD_CHK: begin
        unique case (stat.action)
          ACT_CLEAR: state_next = S_CLR;
          ACT_ADD: begin
            if (!stat.grid_ok || !stat.w_pos || stat.d_neg) state_next = S_IDLE;
            else state_next = S_DIV1_GO;
          end
          ACT_READ: state_next = S_RD_CHK;
          default:  state_next = S_IDLE;
        endcase
      end
      S_CLR:       if (stat.sweep_last) state_next = S_IDLE;
      S_DIV1_GO:   state_next = S_DIV1_WAIT;
      S_DIV1_WAIT: if (stat.div_done) state_next = S_CELL;
      S_CELL:      state_next = stat.cell_bad ? S_IDLE : S_DIV2_GO;
      S_DIV2_GO:   state_next = S_DIV2_WAIT;
      S_DIV2_WAIT: if (stat.div_done) state_next = S_RD_L;
      S_RD_L:      state_next = S_WR_L;
      S_WR_L:      state_next = S_RD_R;
      S_RD_R:      state_next = S_WR_R;
      S_WR_R:      state_next = S_IDLE;
      S_RD_CHK: begin
        if (!stat.grid_ok || stat.idx_bad || stat.total_zero) state_next = S_IDLE;
        else state_next = S_RD_DIV;
      end
      S_RD_DIV:    state_next = stat.rd_sat ? S_IDLE : S_RD_WAIT;
      S_RD_WAIT:   if (stat.div_done) state_next = S_IDLE;
      default:     ;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.fin_code = ST_OK;
    cmd.fin_val  = VAL_ZERO;
    cmd.div_mode = DIV_CELL;
    cmd.rd_sel   = ADDR_LEFT;
    busy     = state != S_IDLE;
    unique case (state)
      S_INIT_CLR: begin
        cmd.sweep = 1'b1;
      end
      S_IDLE: begin
        cmd.load = start;
      end
      S_ADD_CHK: begin
        // add checks happen here, the first multiply runs alongside
        cmd.mul1 = 1'b1;
        priority case (stat.action)
          ACT_ADD: begin
            if (!stat.grid_ok) begin
              cmd.finish   = 1'b1;
              cmd.fin_code = ST_GRID_BAD;
            end else if (!stat.w_pos) begin
              cmd.finish   = 1'b1;
              cmd.fin_code = ST_WEIGHT_BAD;
            end else if (stat.d_neg) begin
              cmd.finish   = 1'b1;
              cmd.fin_code = ST_OUTSIDE;
            end
          end
          ACT_NONE: cmd.finish = 1'b1;
          default: ;
        endcase
      end
      S_CLR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.clr_total = 1'b1;
          cmd.finish    = 1'b1;
        end
      end
      S_DIV1_GO: begin
        cmd.div_go   = 1'b1;
        cmd.div_mode = DIV_CELL;
      end
      S_CELL: begin
        cmd.mul2 = 1'b1;
        if (stat.cell_bad) begin
          cmd.finish   = 1'b1;
          cmd.fin_code = ST_OUTSIDE;
        end
      end
      S_DIV2_GO: begin
        cmd.div_go   = 1'b1;
        cmd.div_mode = DIV_SHARE;
      end
      S_RD_L: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = ADDR_LEFT;
      end
      S_WR_L: cmd.wr_left = 1'b1;
      S_RD_R: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = ADDR_RIGHT;
      end
      S_WR_R: begin
        cmd.wr_right  = 1'b1;
        cmd.add_total = 1'b1;
        cmd.finish    = 1'b1;
      end
      S_RD_CHK: begin
        cmd.rd     = 1'b1;
        cmd.rd_sel = ADDR_INDEX;
        if (!stat.grid_ok) begin
          cmd.finish   = 1'b1;
          cmd.fin_code = ST_GRID_BAD;
        end else if (stat.idx_bad) begin
          cmd.finish   = 1'b1;
          cmd.fin_code = ST_OUTSIDE;
        end else if (stat.total_zero) begin
          cmd.finish   = 1'b1;
          cmd.fin_code = ST_NO_MASS;
        end
      end
      S_RD_DIV: begin
        if (stat.rd_sat) begin
          cmd.finish  = 1'b1;
          cmd.fin_val = VAL_ONES;
        end else begin
          cmd.div_go   = 1'b1;
          cmd.div_mode = DIV_NORM;
        end
      end
      S_RD_WAIT: begin
        cmd.div_mode = DIV_NORM;
        if (stat.div_done) begin
          cmd.finish  = 1'b1;
          cmd.fin_val = VAL_QUO;
        end
      end
      default: ;
    endcase
  end

endmodule

/* src/weighted_linear_binning_top.sv */
// top level of the weighted linear binning block
// Weighted linear binning onto BINS equally spaced grid points between mesh_low and mesh_high,
// all in signed Q16.16. An item is taken when start is high and busy is low; each item gives
// exactly one result on status/bin_value, shown for one cycle with done high, and the receiver
// must take it then since it cannot stall. Items run one at a time. An add passes twice through
// the shared bit-per-cycle divider (48 quotient bits for the cell position, 64 for the weight
// split) and then does a read-modify-write of the left and then the right bin in the bin
// memory. A read that is not saturated is answered through the normalizing divide, which gives
// 32 quotient bits. A clear sweeps the memory one entry per cycle; after reset a clearing pass
// over all BINS entries runs with busy high. Most rejected items answer from a check state;
// a sample past the last cell is only caught after the first divide. Config writes land at
// once and should only be issued while busy is low.
module weighted_linear_binning_top import wlb_pkg::*; #(
  parameter int BINS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  action,
  input  logic [31:0] sample,
  input  logic [31:0] weight,
  input  logic [9:0]  bin_index,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  // result, one item per done strobe
  output logic        done,
  output logic [2:0]  status,
  output logic [31:0] bin_value
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing of every item
  wlb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // bin memory, arithmetic and result registers
  wlb_dp #(
    .BINS (BINS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .action    (action),
    .sample    (sample),
    .weight    (weight),
    .bin_index (bin_index),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .status    (status),
    .bin_value (bin_value)
  );

endmodule

/* verif/testbench.sv */
// self-checking testbench for the weighted linear binning block
module testbench;
  import wlb_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBINS = 1024;
  localparam longint unsigned SUM_MAX = 64'hFFFF_FFFF_FFFF;
  localparam int N_RANDOM = 750;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  action = ACT_CLEAR;
  logic [31:0] sample = '0;
  logic [31:0] weight = '0;
  logic [9:0]  bin_index = '0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        done;
  logic [2:0]  status;
  logic [31:0] bin_value;

  weighted_linear_binning_top #(.BINS(NBINS)) dut (.*);

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the block state
  longint unsigned bin_sum [NBINS];
  longint unsigned mass_total;
  logic [31:0]     grid_lo, grid_hi;

  // expected results, oldest first
  status_t     status_q [$];
  logic [31:0] value_q  [$];
  int          n_fail;

  function automatic longint unsigned sum_sat(longint unsigned a, longint unsigned b);
    longint unsigned s;
    s = a + b;
    return (s > SUM_MAX) ? SUM_MAX : s;
  endfunction

  // restoring divide of one bin by the mass total, Q0.32 saturated
  function automatic logic [31:0] bin_fraction(longint unsigned b, longint unsigned tot);
    longint unsigned rem;
    logic [31:0] q;
    rem = b;
    q = '0;
    if (b >= tot) return '1;
    for (int k = 0; k < 32; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= tot) begin
        rem -= tot;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // works out the result of one item and updates the predicted state
  task automatic predict_binning(input logic [1:0] act, input logic [31:0] smp,
                                 input logic [31:0] wgt, input logic [9:0] idx);
    longint lo, hi, x, w, d, den, num, lbin, r;
    longint unsigned wr, wl;
    status_t st;
    logic [31:0] val;
    lo = longint'(signed'(grid_lo));
    hi = longint'(signed'(grid_hi));
    x = longint'(signed'(smp));
    w = longint'(signed'(wgt));
    st = ST_OK;
    val = '0;
    case (act)
      ACT_CLEAR: begin
        foreach (bin_sum[k]) bin_sum[k] = 0;
        mass_total = 0;
      end
      ACT_ADD: begin
        if (hi <= lo) st = ST_GRID_BAD;
        else if (w <= 0) st = ST_WEIGHT_BAD;
        else begin
          d = x - lo;
          den = hi - lo;
          if (d < 0) st = ST_OUTSIDE;
          else begin
            num = d * (NBINS - 1);
            lbin = num / den;
            r = num - lbin * den;
            if (lbin >= NBINS - 1) st = ST_OUTSIDE;
            else begin
              wr = longint'(unsigned'(w)) * longint'(unsigned'(r)) / longint'(unsigned'(den));
              wl = w - wr;
              bin_sum[lbin] = sum_sat(bin_sum[lbin], wl);
              bin_sum[lbin+1] = sum_sat(bin_sum[lbin+1], wr);
              mass_total = sum_sat(mass_total, w);
            end
          end
        end
      end
      ACT_READ: begin
        if (hi <= lo) st = ST_GRID_BAD;
        else if (int'(idx) >= NBINS) st = ST_OUTSIDE;
        else if (mass_total == 0) st = ST_NO_MASS;
        else val = bin_fraction(bin_sum[idx], mass_total);
      end
      default: ;
    endcase
    status_q = {status_q, st};
    value_q = {value_q, val};
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && done) begin
      if (status_q.size() == 0) begin
        $error("result with nothing expected: status %0d value %h", status, bin_value);
        n_fail++;
      end else begin
        if (status !== status_q[0]) begin
          $error("status: expected %0d actual %0d", status_q[0], status);
          n_fail++;
        end
        if (bin_value !== value_q[0]) begin
          $error("bin_value: expected %h actual %h", value_q[0], bin_value);
          n_fail++;
        end
        void'(status_q.pop_front());
        void'(value_q.pop_front());
      end
    end
  end

  int quiet_left;   // length of the current stretch without idling

  // offers one item and waits for it to be taken; start stays high until the next
  // idle cycle or the next item, the block is busy in the cycle after it takes one
  task automatic send_item(input logic [1:0] act, input logic [31:0] smp,
                           input logic [31:0] wgt, input logic [9:0] idx);
    if (quiet_left > 0) quiet_left--;
    else begin
      while ($urandom_range(99) < 26) begin
        start <= 1'b0;
        @(negedge clk);
      end
    end
    start <= 1'b1;
    action <= act;
    sample <= smp;
    weight <= wgt;
    bin_index <= idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_binning(act, smp, wgt, idx);
    @(negedge clk);
  endtask

  // waits for all results, then lets a clear finish before touching registers
  task automatic drain_results();
    start <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_grid(input logic [31:0] lo, input logic [31:0] hi);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= 1'b0;
    cfg_data <= lo;
    @(negedge clk);
    cfg_index <= 1'b1;
    cfg_data <= hi;
    @(negedge clk);
    cfg_we <= 1'b0;
    grid_lo = lo;
    grid_hi = hi;
  endtask

  // random add item aimed mostly inside the current grid
  task automatic random_add();
    logic [31:0] smp, wgt;
    longint lo, span;
    lo = longint'(signed'(grid_lo));
    span = longint'(signed'(grid_hi)) - lo;
    if ($urandom_range(9) < 8 && span > 0)
      smp = 32'(lo + (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF) % span);
    else smp = $urandom;
    case ($urandom_range(9))
      0: wgt = $urandom;
      1: wgt = 32'h7FFF_FFFF;
      2: wgt = 32'h0001_0000;
      default: wgt = $urandom_range(32'h00FF_FFFF, 1);
    endcase
    send_item(ACT_ADD, smp, wgt, '0);
  endtask

  typedef struct {
    logic [1:0]  act;
    logic [31:0] smp;
    logic [31:0] wgt;
    logic [9:0]  idx;
    bit          typed;   // expected result given in the row
    status_t     st;
    logic [31:0] val;
  } stim_row_t;

  // directed rows on the reset grid 0.0 .. 1023.0
  stim_row_t directed [] = '{
    '{ACT_READ,  32'h0,          32'h0,          10'd0,    1, ST_NO_MASS,    32'h0},
    '{ACT_ADD,   32'h0001_0000,  32'h0,          10'd0,    1, ST_WEIGHT_BAD, 32'h0},
    '{ACT_ADD,   32'h0001_0000,  32'h8000_0000,  10'd0,    1, ST_WEIGHT_BAD, 32'h0},
    '{ACT_ADD,   32'hFFFF_FFFF,  32'h0001_0000,  10'd0,    1, ST_OUTSIDE,    32'h0},
    '{ACT_ADD,   32'h03FF_0000,  32'h0001_0000,  10'd0,    1, ST_OUTSIDE,    32'h0},
    '{ACT_ADD,   32'h7FFF_FFFF,  32'h0001_0000,  10'd0,    1, ST_OUTSIDE,    32'h0},
    '{ACT_ADD,   32'h8000_0000,  32'h0001_0000,  10'd0,    1, ST_OUTSIDE,    32'h0},
    '{ACT_ADD,   32'h0000_0000,  32'h0001_0000,  10'd0,    1, ST_OK,         32'h0},
    '{ACT_READ,  32'h0,          32'h0,          10'd0,    1, ST_OK,         32'hFFFF_FFFF},
    '{ACT_READ,  32'h0,          32'h0,          10'd1023, 1, ST_OK,         32'h0},
    '{ACT_NONE,  32'hFFFF_FFFF,  32'hFFFF_FFFF,  10'd1023, 1, ST_OK,         32'h0},
    '{ACT_ADD,   32'h03FE_8000,  32'h7FFF_FFFF,  10'd0,    0, ST_OK,         32'h0},
    '{ACT_ADD,   32'h03FE_FFFF,  32'h7FFF_FFFF,  10'd0,    0, ST_OK,         32'h0},
    '{ACT_ADD,   32'h0000_0001,  32'h0000_0001,  10'd0,    0, ST_OK,         32'h0},
    '{ACT_READ,  32'h0,          32'h0,          10'd1022, 0, ST_OK,         32'h0},
    '{ACT_READ,  32'h0,          32'h0,          10'd1023, 0, ST_OK,         32'h0},
    '{ACT_READ,  32'h0,          32'h0,          10'd0,    0, ST_OK,         32'h0},
    '{ACT_CLEAR, 32'h0,          32'h0,          10'd0,    1, ST_OK,         32'h0},
    '{ACT_READ,  32'h0,          32'h0,          10'd5,    1, ST_NO_MASS,    32'h0}
  };

  initial begin
    int phase_items;
    n_fail = 0;
    quiet_left = 0;
    foreach (bin_sum[k]) bin_sum[k] = 0;
    mass_total = 0;
    grid_lo = 32'h0;
    grid_hi = 32'd67043328;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: typed rows compare against the row too
    foreach (directed[n]) begin
      send_item(directed[n].act, directed[n].smp, directed[n].wgt, directed[n].idx);
      if (directed[n].typed && (status_q[$] !== directed[n].st ||
                                value_q[$] !== directed[n].val)) begin
        $error("row %0d: status/bin_value predicted %0d/%h, table says %0d/%h", n,
               status_q[$], value_q[$], directed[n].st, directed[n].val);
        n_fail++;
      end
    end

    // invalid grids, clear still answers ok
    write_grid(32'h0001_0000, 32'h0001_0000);
    send_item(ACT_ADD, 32'h0001_0000, 32'h0001_0000, '0);
    send_item(ACT_READ, '0, '0, 10'd3);
    send_item(ACT_CLEAR, '0, '0, '0);
    write_grid(32'h7FFF_FFFF, 32'h8000_0000);
    send_item(ACT_ADD, 32'h7FFF_FFFF, 32'h0001_0000, '0);

    // random phases over several grids, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_grid(32'h8000_0000, 32'h7FFF_FFFF);
        1: write_grid(32'hFFF0_0000, 32'h0010_0000);
        2: write_grid(32'h0000_0000, 32'h0000_03FF);
        3: write_grid($urandom, $urandom);
        4: write_grid(32'h0000_0000, 32'd67043328);
        default: write_grid(32'h7FFF_0000, 32'h7FFF_FFFF);
      endcase
      quiet_left = (ph == 1) ? 60 : 0;
      phase_items = N_RANDOM / 6;
      send_item(ACT_CLEAR, '0, '0, '0);
      for (int n = 0; n < phase_items; n++) begin
        case ($urandom_range(19))
          0: send_item(ACT_CLEAR, $urandom, $urandom, 10'($urandom));
          1: send_item(ACT_NONE, $urandom, $urandom, 10'($urandom));
          2: send_item(ACT_ADD, $urandom, $urandom, 10'($urandom));
          3, 4, 5, 6, 7: send_item(ACT_READ, $urandom, $urandom, 10'($urandom));
          default: random_add();
        endcase
      end
    end

    drain_results();
    repeat (200) @(negedge clk);
    if (n_fail == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // overall time limit
  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
